// ===== rtl/tsk_pkg.sv =====
// tsk_pkg: types, register indexes, reset values and the s-box and bit
// permutation functions of the toy spn counter-mode keystream block.
// No dependencies.
package tsk_pkg;

  localparam int unsigned CFG_INDEX_W = 2;

  localparam logic [CFG_INDEX_W-1:0] CFG_ROUND_KEY  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SBOX_TABLE = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_PERM_TABLE = 2'd2;

  localparam logic [31:0] ROUND_KEY_RESET  = 32'h0000_0000;
  localparam logic [63:0] SBOX_TABLE_RESET = 64'hFEDC_BA98_7654_3210;
  localparam logic [31:0] PERM_TABLE_RESET = 32'h8765_4321;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_PROCESS = 1'b1;

  typedef struct packed {
    logic [31:0] round_key;
    logic [63:0] sbox_table;
    logic [31:0] perm_table;
  } cfg_t;

  function automatic logic [7:0] sub_byte(input logic [7:0] b, input logic [63:0] sbox);
    logic [5:0] hi_idx;
    logic [5:0] lo_idx;
    hi_idx = {b[7:4], 2'b00};
    lo_idx = {b[3:0], 2'b00};
    return {sbox[hi_idx +: 4], sbox[lo_idx +: 4]};
  endfunction

  // nibble i picks source position p (1 = msb) for output bit 7-i;
  // positions outside 1..8 give a zero bit
  function automatic logic [7:0] perm_byte(input logic [7:0] b, input logic [31:0] perm);
    logic [7:0] r;
    logic [3:0] p;
    logic [3:0] src;
    r = 8'h00;
    for (int i = 0; i < 8; i++) begin
      p   = perm[4*i +: 4];
      src = 4'd8 - p;
      if (p >= 4'd1 && p <= 4'd8) begin
        r[7-i] = b[src[2:0]];
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/tsk_cfg_regs.sv =====
// tsk_cfg_regs: configuration register file (round key, s-box, permutation).
// Depends on tsk_pkg.
module tsk_cfg_regs
  import tsk_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [63:0]            cfg_data,
  output cfg_t                   cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.round_key  <= ROUND_KEY_RESET;
      cfg.sbox_table <= SBOX_TABLE_RESET;
      cfg.perm_table <= PERM_TABLE_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ROUND_KEY:  cfg.round_key  <= cfg_data[31:0];
        CFG_SBOX_TABLE: cfg.sbox_table <= cfg_data;
        CFG_PERM_TABLE: cfg.perm_table <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/tsk_round.sv =====
// tsk_round: one network round: key xor, nibble s-box, bit permutation.
// Depends on tsk_pkg.
module tsk_round
  import tsk_pkg::*;
(
  input  logic [7:0]  din,
  input  logic [7:0]  key,
  input  logic [63:0] sbox_table,
  input  logic [31:0] perm_table,
  output logic [7:0]  dout
);

  logic [7:0] mixed;
  logic [7:0] subbed;

  assign mixed  = din ^ key;
  assign subbed = sub_byte(mixed, sbox_table);
  assign dout   = perm_byte(subbed, perm_table);

endmodule

// ===== rtl/toy_spn_ctr_keystream.sv =====
// Counter-mode byte cipher over an 8-bit substitution-permutation network.
// An input transaction with tuser 0 loads the counter from tdata and gives no
// output; one with tuser 1 gives tdata xor E(counter) and advances the counter
// modulo 256. The block takes one transaction per cycle while the output is not
// stalled; a result passes through the stage register and then the output
// register, with the three unrolled rounds sitting combinationally between them.
// The counter moves at acceptance, so back-to-back items each see their own value.
// Configuration writes are taken every cycle and must happen while idle.
// Depends on tsk_pkg, tsk_cfg_regs and tsk_round.
module toy_spn_ctr_keystream
  import tsk_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [7:0]             s_axis_tdata,   // [7:0] data_byte
  input  logic                   s_axis_tuser,   // [0] op
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [7:0]             m_axis_tdata,   // [7:0] out_byte
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [63:0]            cfg_data
);

  localparam int unsigned ROUNDS = 3;

  cfg_t       cfg;
  logic [7:0] counter;
  logic       stage_valid;
  logic [7:0] stage_data;
  logic [7:0] stage_ctr;
  logic       stage_advance;
  logic       s_accept;
  logic [7:0] round_val [ROUNDS+1];
  logic [7:0] keystream;

  tsk_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign stage_advance = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = !stage_valid || stage_advance;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  // counter and stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      counter     <= 8'h00;
      stage_valid <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        stage_valid <= s_accept && (s_axis_tuser == OP_PROCESS);
      end
      if (s_accept) begin
        if (s_axis_tuser == OP_LOAD) begin
          counter <= s_axis_tdata;
        end else begin
          counter <= counter + 8'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      stage_data <= s_axis_tdata;
      stage_ctr  <= counter;
    end
  end

  assign round_val[0] = stage_ctr;

  for (genvar r = 0; r < ROUNDS; r++) begin : g_round
    tsk_round u_round (
      .din        (round_val[r]),
      .key        (cfg.round_key[8*r +: 8]),
      .sbox_table (cfg.sbox_table),
      .perm_table (cfg.perm_table),
      .dout       (round_val[r+1])
    );
  end

  assign keystream = round_val[ROUNDS] ^ cfg.round_key[31:24];

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (stage_advance) begin
      m_axis_tvalid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_advance && stage_valid) begin
      m_axis_tdata <= stage_data ^ keystream;
    end
  end

  a_ctr_step: assert property (@(posedge clk) disable iff (rst)
    (s_accept && s_axis_tuser == OP_PROCESS) |=> counter == $past(counter) + 8'd1)
    else $error("counter did not advance after a data transaction");

  a_ctr_load: assert property (@(posedge clk) disable iff (rst)
    (s_accept && s_axis_tuser == OP_LOAD) |=> counter == $past(s_axis_tdata))
    else $error("counter not loaded");

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    (stage_valid && !stage_advance) |=> stage_valid && $stable(stage_ctr))
    else $error("stalled stage item lost");

  a_stage_move: assert property (@(posedge clk) disable iff (rst)
    (stage_valid && stage_advance) |=> m_axis_tvalid)
    else $error("stage item did not reach output");

endmodule
